/* rtl/core/tcrg_pkg.sv */
package tcrg_pkg;

   localparam int TileSize = 16;
   localparam int PixW     = 12;
   localparam int PosW     = 20;
   localparam int DirW     = 16;
   localparam int CornerW  = 3 * PosW;
   localparam int StepW    = 17;
   localparam int CsrIdxW  = 3;

   // Register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] CSR_TOP_LEFT     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_TOP_RIGHT    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_BOTTOM_LEFT  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_BOTTOM_RIGHT = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_EYE          = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_STEP_X       = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_STEP_Y       = 3'd6;

   typedef struct packed {
      logic [PixW-1:0] tile_x;
      logic [PixW-1:0] tile_y;
   } req_type;

   typedef struct packed {
      logic [1:0]             corner_index;
      logic signed [PosW-1:0] origin_x;
      logic signed [PosW-1:0] origin_y;
      logic signed [PosW-1:0] origin_z;
      logic signed [DirW-1:0] dir_x;
      logic signed [DirW-1:0] dir_y;
      logic signed [DirW-1:0] dir_z;
      logic                   degenerate;
      logic                   last_corner;
   } rsp_type;

   typedef struct packed {
      logic [CornerW-1:0] top_left;
      logic [CornerW-1:0] top_right;
      logic [CornerW-1:0] bottom_left;
      logic [CornerW-1:0] bottom_right;
      logic [CornerW-1:0] eye;
      logic [StepW-1:0]   step_x;
      logic [StepW-1:0]   step_y;
   } csr_type;

   // Handoff from the request queue to the ray engine
   typedef struct packed {
      logic    valid;
      req_type tile;
   } tile_chan_type;

endpackage

/* rtl/core/tcrg_front.sv */
module tcrg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcrg_pkg::req_type      req_data,
   output tcrg_pkg::tile_chan_type tile_out,
   input  logic                   tile_pop
);
   import tcrg_pkg::*;

   req_type    q_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   assign req_stall      = (cnt_ff == 2'd2);
   assign push           = req_valid && !req_stall;
   assign pop            = tile_pop && tile_out.valid;
   assign tile_out.valid = (cnt_ff != 2'd0);
   assign tile_out.tile  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            q_ff[wp_ff] <= req_data;
            wp_ff       <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

/* rtl/core/tcrg_back.sv */
module tcrg_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tcrg_pkg::csr_type       csr,
   input  tcrg_pkg::tile_chan_type tile_in,
   output logic                    tile_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tcrg_pkg::rsp_type       rsp_data
);
   import tcrg_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_WGT, S_LERP, S_SQ, S_SQRT, S_DSET, S_DIV, S_OUT
   } state_type;

   function automatic logic signed [PosW-1:0] axis_of(input logic [CornerW-1:0] v,
                                                      input logic [1:0] ax);
      logic signed [PosW-1:0] r;
      case (ax)
         2'd0:    r = v[PosW-1:0];
         2'd1:    r = v[2*PosW-1:PosW];
         default: r = v[3*PosW-1:2*PosW];
      endcase
      return r;
   endfunction

   function automatic logic signed [PosW-1:0] sat_pos(input logic signed [37:0] v);
      logic signed [PosW-1:0] r;
      if (v > 38'sd524287) begin
         r = 20'sd524287;
      end else if (v < -38'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[PosW-1:0];
      end
      return r;
   endfunction

   state_type              state_ff;
   req_type                tile_ff;
   logic [1:0]             corner_ff;
   logic [29:0]            alpha_ff;
   logic [29:0]            beta_ff;
   logic [1:0]             ax_ff;
   logic [1:0]             stg_ff;
   logic                   ph_ff;
   logic signed [51:0]     prod_ff;
   logic signed [PosW-1:0] top_ff;
   logic signed [PosW-1:0] bot_ff;
   logic signed [PosW-1:0] org_ff [3];
   logic signed [PosW:0]   d_ff [3];
   logic [40:0]            sq_ff;
   logic [41:0]            sum_ff;
   logic [63:0]            rem_ff;
   logic [63:0]            root_ff;
   logic [63:0]            bit_ff;
   logic [31:0]            len_ff;
   logic [45:0]            num_ff;
   logic [45:0]            quo_ff;
   logic [32:0]            drem_ff;
   logic [5:0]             cnt_ff;
   logic signed [DirW-1:0] dir_ff [3];
   logic                   degen_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [12:0]            px;
   logic [12:0]            py;
   logic signed [PosW-1:0] a_sel;
   logic signed [PosW-1:0] b_sel;
   logic [29:0]            w_sel;
   logic signed [PosW:0]   diff;
   logic signed [30:0]     wext;
   logic signed [51:0]     mul_res;
   logic signed [51:0]     rnd;
   logic signed [35:0]     shr;
   logic signed [37:0]     lerp_sum;
   logic signed [PosW-1:0] lerp_res;
   logic signed [PosW-1:0] eye_sel;
   logic signed [PosW:0]   d_sel;
   logic signed [41:0]     sq_res;
   logic [41:0]            sum_nx;
   logic [63:0]            trial;
   logic [63:0]            root_nx;
   logic [19:0]            abs_d;
   logic [33:0]            r2;
   logic                   qbit;
   logic [45:0]            q_fin;
   logic signed [DirW-1:0] dir_fin;
   logic                   out_free;

   assign tile_pop  = (state_ff == S_IDLE) && tile_in.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign px = {1'b0, tile_ff.tile_x} + (corner_ff[0] ? 13'(TileSize) : 13'd0);
   assign py = {1'b0, tile_ff.tile_y} + (corner_ff[1] ? 13'(TileSize) : 13'd0);

   // Lerp operands: top edge, bottom edge, then down between them
   always_comb begin
      case (stg_ff)
         2'd0: begin
            a_sel = axis_of(csr.top_left, ax_ff);
            b_sel = axis_of(csr.top_right, ax_ff);
            w_sel = alpha_ff;
         end
         2'd1: begin
            a_sel = axis_of(csr.bottom_left, ax_ff);
            b_sel = axis_of(csr.bottom_right, ax_ff);
            w_sel = alpha_ff;
         end
         default: begin
            a_sel = top_ff;
            b_sel = bot_ff;
            w_sel = beta_ff;
         end
      endcase
   end

   assign diff     = {b_sel[PosW-1], b_sel} - {a_sel[PosW-1], a_sel};
   assign wext     = $signed({1'b0, w_sel});
   assign mul_res  = wext * diff;
   assign rnd      = prod_ff + 52'sd32768;
   assign shr      = rnd[51:16];
   assign lerp_sum = {{2{shr[35]}}, shr} + {{18{a_sel[PosW-1]}}, a_sel};
   assign lerp_res = sat_pos(lerp_sum);
   assign eye_sel  = axis_of(csr.eye, ax_ff);

   always_comb begin
      case (ax_ff)
         2'd0:    d_sel = d_ff[0];
         2'd1:    d_sel = d_ff[1];
         2'd2:    d_sel = d_ff[2];
         default: d_sel = '0;
      endcase
   end

   assign sq_res  = d_sel * d_sel;
   assign sum_nx  = sum_ff + {1'b0, sq_ff};
   assign trial   = root_ff + bit_ff;
   assign root_nx = (rem_ff >= trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   assign abs_d   = d_sel[PosW] ? 20'(-d_sel) : d_sel[PosW-1:0];
   assign r2      = {drem_ff, num_ff[45]};
   assign qbit    = (r2 >= {1'b0, len_ff, 1'b0});
   assign q_fin   = {quo_ff[44:0], qbit};

   always_comb begin
      if (d_sel[PosW]) begin
         dir_fin = (q_fin > 46'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, q_fin[15:0]}));
      end else begin
         dir_fin = (q_fin > 46'd32767) ? 16'sd32767 : $signed(q_fin[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= 2'd0;
         ax_ff        <= 2'd0;
         stg_ff       <= 2'd0;
         ph_ff        <= 1'b0;
         cnt_ff       <= 6'd0;
      end else begin
         // Load a new ray, or drop the current one once it is taken
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (tile_in.valid) begin
                  tile_ff   <= tile_in.tile;
                  corner_ff <= 2'd0;
                  state_ff  <= S_WGT;
               end
            end
            S_WGT: begin
               alpha_ff <= csr.step_x * px;
               beta_ff  <= csr.step_y * py;
               ax_ff    <= 2'd0;
               stg_ff   <= 2'd0;
               ph_ff    <= 1'b0;
               state_ff <= S_LERP;
            end
            S_LERP: begin
               if (!ph_ff) begin
                  prod_ff <= mul_res;
                  ph_ff   <= 1'b1;
               end else begin
                  ph_ff <= 1'b0;
                  case (stg_ff)
                     2'd0:    top_ff <= lerp_res;
                     2'd1:    bot_ff <= lerp_res;
                     default: begin
                        org_ff[ax_ff] <= lerp_res;
                        d_ff[ax_ff]   <= {lerp_res[PosW-1], lerp_res}
                                         - {eye_sel[PosW-1], eye_sel};
                     end
                  endcase
                  if (stg_ff == 2'd2) begin
                     stg_ff <= 2'd0;
                     if (ax_ff == 2'd2) begin
                        ax_ff    <= 2'd0;
                        sq_ff    <= '0;
                        sum_ff   <= '0;
                        state_ff <= S_SQ;
                     end else begin
                        ax_ff <= ax_ff + 2'd1;
                     end
                  end else begin
                     stg_ff <= stg_ff + 2'd1;
                  end
               end
            end
            S_SQ: begin
               sum_ff <= sum_nx;
               if (ax_ff != 2'd3) begin
                  sq_ff <= sq_res[40:0];
                  ax_ff <= ax_ff + 2'd1;
               end else begin
                  ax_ff <= 2'd0;
                  if (sum_nx == 42'd0) begin
                     degen_ff  <= 1'b1;
                     dir_ff[0] <= '0;
                     dir_ff[1] <= '0;
                     dir_ff[2] <= '0;
                     state_ff  <= S_OUT;
                  end else begin
                     degen_ff <= 1'b0;
                     rem_ff   <= {2'b00, sum_nx, 20'd0};
                     root_ff  <= '0;
                     bit_ff   <= 64'd1 << 62;
                     state_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
               end
               root_ff <= root_nx;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff == 64'd1) begin
                  len_ff   <= root_nx[31:0];
                  state_ff <= S_DSET;
               end
            end
            S_DSET: begin
               num_ff   <= {1'b0, abs_d, 25'd0} + {14'd0, len_ff};
               quo_ff   <= '0;
               drem_ff  <= '0;
               cnt_ff   <= 6'd45;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               drem_ff <= qbit ? 33'(r2 - {1'b0, len_ff, 1'b0}) : r2[32:0];
               quo_ff  <= q_fin;
               num_ff  <= {num_ff[44:0], 1'b0};
               cnt_ff  <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  dir_ff[ax_ff] <= dir_fin;
                  if (ax_ff == 2'd2) begin
                     ax_ff    <= 2'd0;
                     state_ff <= S_OUT;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= S_DSET;
                  end
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_ff.corner_index <= corner_ff;
                  rsp_ff.origin_x     <= org_ff[0];
                  rsp_ff.origin_y     <= org_ff[1];
                  rsp_ff.origin_z     <= org_ff[2];
                  rsp_ff.dir_x        <= dir_ff[0];
                  rsp_ff.dir_y        <= dir_ff[1];
                  rsp_ff.dir_z        <= dir_ff[2];
                  rsp_ff.degenerate   <= degen_ff;
                  rsp_ff.last_corner  <= (corner_ff == 2'd3);
                  if (corner_ff == 2'd3) begin
                     state_ff <= S_IDLE;
                  end else begin
                     corner_ff <= corner_ff + 2'd1;
                     state_ff  <= S_WGT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/core/tile_corner_ray_generator_core.sv */
// Channel   Ports                               Moves
// request   req_valid, req_stall, req_data      one tile (tile_x, tile_y)
// response  rsp_valid, rsp_stall, rsp_data      one corner ray, four per request
// config    csr_we, csr_index, csr_wdata        one register write, no read-back
//
// Each corner passes through the ray engine in order: a weight step, the nine
// lerps on one shared multiplier, the sum of squares, the bit-pair square root,
// three radix-2 divisions on one divider (a set-up step and 46 quotient bits
// each) and an output step; a degenerate corner skips root and divide. The
// engine takes a request from the queue while idle and then walks its corners.
// Reset is synchronous and clears the queue pointers, the engine control state
// and the configuration registers to 0; data registers are not reset.
// A two-entry request queue lets requests arrive while the engine is busy, and
// the registered response holds while rsp_stall is high.
module tile_corner_ray_generator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tcrg_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tcrg_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [tcrg_pkg::CsrIdxW-1:0] csr_index,
   input  logic [tcrg_pkg::CornerW-1:0] csr_wdata
);
   import tcrg_pkg::*;

   csr_type       csr_ff;
   tile_chan_type tile_chan;
   logic          tile_pop;

   // Register file: indexes beyond the list drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOP_LEFT:     csr_ff.top_left     <= csr_wdata;
            CSR_TOP_RIGHT:    csr_ff.top_right    <= csr_wdata;
            CSR_BOTTOM_LEFT:  csr_ff.bottom_left  <= csr_wdata;
            CSR_BOTTOM_RIGHT: csr_ff.bottom_right <= csr_wdata;
            CSR_EYE:          csr_ff.eye          <= csr_wdata;
            CSR_STEP_X:       csr_ff.step_x       <= csr_wdata[StepW-1:0];
            CSR_STEP_Y:       csr_ff.step_y       <= csr_wdata[StepW-1:0];
            default: ;
         endcase
      end
   end

   // Front: queue incoming requests
   tcrg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .tile_out  (tile_chan),
      .tile_pop  (tile_pop)
   );

   // Back: walk the four corners and hold each ray in the output register
   tcrg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .tile_in   (tile_chan),
      .tile_pop  (tile_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_last_is_fourth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_corner |-> rsp_data.corner_index == 2'd3)
      else $error("last_corner on a corner other than bottom-right");

   a_fourth_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.corner_index == 2'd3 |-> rsp_data.last_corner)
      else $error("bottom-right corner without last_corner");

   a_degen_zero_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.dir_x == 16'sd0 && rsp_data.dir_y == 16'sd0 && rsp_data.dir_z == 16'sd0)
      else $error("degenerate ray with nonzero direction");

endmodule
